/* rtl/core/shl_pkg.sv */
package shl_pkg;

    localparam int MaxSegmentsDefault = 64;

    localparam int CoordW  = 16;
    localparam int HeightW = 24;
    localparam int NumW    = 43;   // (y1*dx + dy*off) * 256
    localparam int DivW    = 17;   // dx range 0..65535

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_MISS    = 3'd0,
        ST_HIT     = 3'd1,
        ST_STORED  = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] seg_left_x;
        logic signed [15:0] seg_left_y;
        logic signed [15:0] seg_right_x;
        logic signed [15:0] seg_right_y;
        logic signed [15:0] query_x;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [23:0] height_y;
    } out_word_t;

    typedef struct packed {
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
    } seg_t;

    // query token handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               found;
        logic signed [15:0] qx;
        seg_t               seg;
    } lane_t;

    typedef struct packed {
        logic   wr_en;
        seg_t   seg;
    } cell_wr_t;

endpackage

/* rtl/core/shl_cell.sv */
module shl_cell
    import shl_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7,
    parameter int IW  = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_wr_t      wr,
    input  logic [IW-1:0] wr_idx,
    input  logic [CW-1:0] count,
    input  lane_t         lane_in,
    output lane_t         lane_out
);

    seg_t  seg_reg;
    lane_t lane_reg;
    lane_t lane_next;
    logic  active_reg;
    logic  valid;

    assign valid = CW'(IDX) < count;

    // hold this cell's segment
    always_ff @(posedge clk)
    begin
        if (wr.wr_en && (wr_idx == IW'(IDX)))
        begin
            seg_reg <= wr.seg;
        end
    end

    // take over the token when this later segment holds x
    always_comb
    begin
        lane_next = lane_in;
        if (lane_in.active && valid && (lane_in.qx >= seg_reg.lx)
            && (lane_in.qx <= seg_reg.rx))
        begin
            lane_next.found = 1'b1;
            lane_next.seg   = seg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= lane_next.active;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    always_comb
    begin
        lane_out        = lane_reg;
        lane_out.active = active_reg;
    end

endmodule

/* rtl/core/shl_div.sv */
module shl_div
    import shl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NumW-1:0] dividend,
    input  logic [DivW-1:0] divisor,
    output logic            done,
    output logic [NumW-1:0] quotient
);

    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] quo_reg;
    logic [DivW-1:0] rem_reg;
    logic [DivW-1:0] dvs_reg;
    logic [CntW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DivW:0]   rem_shift;
    logic [DivW:0]   rem_diff;

    // one restoring step per cycle, quotient bits shift in at the bottom
    assign rem_shift = {rem_reg, quo_reg[NumW-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(NumW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!rem_diff[DivW])
            begin
                rem_reg <= rem_diff[DivW-1:0];
                quo_reg <= {quo_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[DivW-1:0];
                quo_reg <= {quo_reg[NumW-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/segment_height_lookup_core.sv */
// Ground height lookup over a table of line segments.
// Input channel in_valid/in_stall carries in_word: load (append a segment),
// query (height at query_x) or clear. Output channel out_valid/out_stall
// carries out_word: one status/height word per input word.
// Load, clear and unused codes answer one cycle after acceptance.
// A query passes a token down a row of MAX_SEGMENTS cells, one cell per
// cycle, the last matching cell winning; then a multiply state, a sum
// state and a restoring divider. A vertical segment skips the divider and
// a miss goes from the scan straight to the output state.
// One item is in work at a time; in_stall is high while a query runs.
// The output word sits in a register: while out_stall holds it, in_stall
// stays high and no new word is taken until the slot frees.
// Reset empties the table (count to zero) and drops any word in flight.
// Stored segments are kept in cells and need no clearing.
module segment_height_lookup_core
    import shl_pkg::*;
#(
    parameter int MAX_SEGMENTS = MaxSegmentsDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_MUL  = 6'b000100,
        S_SUM  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;
    logic              accept;
    logic              out_free;
    cell_wr_t          wr;
    lane_t             lane_head;
    lane_t             lanes [0:MAX_SEGMENTS];

    seg_t                  seg_reg;
    logic signed [15:0]    qx_reg;
    logic                  hit_reg;
    logic signed [32:0]    p1_reg;
    logic signed [33:0]    p2_reg;
    logic [DivW-1:0]       dx_reg;
    logic                  neg_reg;
    logic signed [23:0]    height_reg;

    logic signed [16:0]    dx_s;
    logic signed [16:0]    dy_s;
    logic signed [16:0]    off_s;
    logic signed [34:0]    sum_s;
    logic signed [NumW-1:0] num_s;
    logic [NumW-1:0]       mag_s;
    logic                  div_done;
    logic [NumW-1:0]       quo;
    logic [HeightW-1:0]    quo_lo;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    // write a loaded segment into the next free cell
    assign wr.wr_en = accept && (in_word.req_type == REQ_LOAD)
                      && (count_reg < CW'(MAX_SEGMENTS));
    assign wr.seg   = '{lx: in_word.seg_left_x, ly: in_word.seg_left_y,
                        rx: in_word.seg_right_x, ry: in_word.seg_right_y};

    // inject a query token at the head of the row
    always_comb
    begin
        lane_head        = '0;
        lane_head.active = accept && (in_word.req_type == REQ_QUERY);
        lane_head.qx     = in_word.query_x;
    end

    assign lanes[0] = lane_head;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SEGMENTS; gi++)
        begin : g_cell
            shl_cell #(
                .IDX (gi),
                .CW  (CW),
                .IW  (IW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr       (wr),
                .wr_idx   (count_reg[IW-1:0]),
                .count    (count_reg),
                .lane_in  (lanes[gi]),
                .lane_out (lanes[gi+1])
            );
        end
    endgenerate

    // interpolation operands
    assign dx_s   = 17'(seg_reg.rx) - 17'(seg_reg.lx);
    assign dy_s   = 17'(seg_reg.ry) - 17'(seg_reg.ly);
    assign off_s  = 17'(qx_reg) - 17'(seg_reg.lx);
    assign sum_s  = 35'(p1_reg) + 35'(p2_reg);
    assign num_s  = {sum_s, 8'd0};
    assign mag_s  = num_s[NumW-1] ? NumW'(-num_s) : NumW'(num_s);
    assign quo_lo = quo[HeightW-1:0];

    shl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SUM && dx_reg != '0),
        .dividend (mag_s),
        .divisor  (dx_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // control: sequence, table count and output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_word.req_type)
                            REQ_LOAD:
                            begin
                                out_valid_reg <= 1'b1;
                                if (wr.wr_en)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            REQ_QUERY: state_reg <= S_SCAN;
                            REQ_CLEAR:
                            begin
                                count_reg     <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            default: out_valid_reg <= 1'b1;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (lanes[MAX_SEGMENTS].active)
                    begin
                        state_reg <= lanes[MAX_SEGMENTS].found ? S_MUL : S_OUT;
                    end
                end
                S_MUL: state_reg <= S_SUM;
                S_SUM: state_reg <= (dx_reg == '0) ? S_OUT : S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath: capture, multiply, sum, divide, output word
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_word_reg.height_y <= '0;
                    case (in_word.req_type)
                        REQ_LOAD:  out_word_reg.status <= wr.wr_en ? ST_STORED : ST_FULL;
                        REQ_CLEAR: out_word_reg.status <= ST_CLEARED;
                        default:   out_word_reg.status <= ST_MISS;
                    endcase
                end
            end
            S_SCAN:
            begin
                seg_reg    <= lanes[MAX_SEGMENTS].seg;
                qx_reg     <= lanes[MAX_SEGMENTS].qx;
                hit_reg    <= lanes[MAX_SEGMENTS].found;
                height_reg <= '0;
            end
            S_MUL:
            begin
                p1_reg <= seg_reg.ly * dx_s;
                p2_reg <= dy_s * off_s;
                dx_reg <= dx_s[DivW-1:0];
            end
            S_SUM:
            begin
                neg_reg    <= num_s[NumW-1];
                height_reg <= {seg_reg.ly, 8'd0};
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    height_reg <= neg_reg ? -quo_lo : quo_lo;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_word_reg.status   <= hit_reg ? ST_HIT : ST_MISS;
                    out_word_reg.height_y <= hit_reg ? height_reg : '0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // table count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count above capacity");

    // only a hit carries a height
    a_height_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.status != ST_HIT) |-> out_word.height_y == '0)
        else $error("nonzero height without hit");

    // divider finishes only while waiting on it
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider done outside divide phase");

    // a token leaves the row only during a scan
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        lanes[MAX_SEGMENTS].active |-> state_reg == S_SCAN)
        else $error("scan token outside scan");

endmodule
